>>> hdl/assert_macros.svh
// assertion macros for the filter rtl
// expects signals named clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define FLB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FLB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/flb_pkg.sv
// package for the 17-tap blackman low-pass fir
// holds default sizes, the q1.15 tap table and the flow-control struct
`default_nettype none

package flb_pkg;

  localparam int TapsDef       = 17;
  localparam int SampleBitsDef = 10;
  localparam int CoefFracDef   = 15;
  localparam int CoefW         = 16;
  localparam int RomDepth      = 17;

  typedef logic [CoefW-1:0] flb_coef_t;

  typedef struct packed {
    logic ready;  // stage can take a transaction this cycle
    logic take;   // input transaction accepted, chain advances
  } flb_flow_t;

  // windowed sinc taps, tap 0 weights the newest sample; zero past the table
  function automatic flb_coef_t flb_coef(input int idx);
    flb_coef_t c;
    case (idx)
      0:       c = 16'd0;
      1:       c = 16'd53;
      2:       c = 16'd246;
      3:       c = 16'd651;
      4:       c = 16'd1322;
      5:       c = 16'd2230;
      6:       c = 16'd3234;
      7:       c = 16'd4104;
      8:       c = 16'd4672;
      9:       c = 16'd4595;
      10:      c = 16'd4072;
      11:      c = 16'd3191;
      12:      c = 16'd2189;
      13:      c = 16'd1290;
      14:      c = 16'd632;
      15:      c = 16'd237;
      16:      c = 16'd51;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/flb_sample_if.sv
// valid/ready channel interfaces for filter samples in and results out
// standalone, no package dependency
`default_nettype none

interface flb_sample_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface flb_filtered_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

>>> hdl/flb_cell.sv
// one tap of the transposed fir chain: coef times sample plus upstream partial sum
// depends on flb_pkg
`default_nettype none

module flb_cell #(
  parameter int                 SAMPLE_BITS = 10,
  parameter int                 ACC_W       = 31,
  parameter flb_pkg::flb_coef_t COEF        = '0
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic [SAMPLE_BITS-1:0] x,
  input  wire logic [ACC_W-1:0]       acc_in,
  output      logic [ACC_W-1:0]       acc_r
);
  import flb_pkg::*;

  localparam int ProdW = SAMPLE_BITS + CoefW;

  logic [ProdW-1:0] prod;
  logic [ACC_W-1:0] acc_nxt;

  assign prod    = ProdW'(x) * ProdW'(COEF);
  assign acc_nxt = ACC_W'(prod) + acc_in;

  // partial sums start at zero so missing history counts as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/flb_out_stage.sv
// output stage: tracks the pending sum, scales, saturates and drives the result channel
// depends on flb_pkg, flb_filtered_if and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module flb_out_stage #(
  parameter int SAMPLE_BITS    = 10,
  parameter int COEF_FRAC_BITS = 15,
  parameter int ACC_W          = 31
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [ACC_W-1:0]  acc0,
  output flb_pkg::flb_flow_t     flow,
  flb_filtered_if.source         out_flt
);
  import flb_pkg::*;

  logic                   a_v_r, a_v_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_data_r;
  logic                   load;
  logic [ACC_W-1:0]       shifted;
  logic [SAMPLE_BITS-1:0] sat;

  assign load       = a_v_r && (!out_valid_r || out_flt.ready);
  assign flow.ready = !a_v_r || !out_valid_r || out_flt.ready;
  assign flow.take  = in_valid && flow.ready;

  // sum is never negative, so the shift truncates toward zero
  assign shifted = acc0 >> COEF_FRAC_BITS;
  assign sat     = (|shifted[ACC_W-1:SAMPLE_BITS]) ? '1 : shifted[SAMPLE_BITS-1:0];

  always_comb begin
    a_v_nxt = a_v_r;
    if (flow.take) begin
      a_v_nxt = 1'b1;
    end else if (load) begin
      a_v_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_flt.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_v_r       <= a_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= sat;
    end
  end

  assign out_flt.valid    = out_valid_r;
  assign out_flt.filtered = out_data_r;

  `FLB_ASSERT_NXT(a_take_sets_pend, flow.take, a_v_r, "accepted sample left no pending sum")
  `FLB_ASSERT_IMP(a_stall_full, !flow.ready, a_v_r && out_valid_r, "stalled with a free slot")
  `FLB_ASSERT_NXT(a_pend_kept, a_v_r && !load && !flow.take, a_v_r, "pending sum dropped")

endmodule

`default_nettype wire

>>> hdl/fir_lowpass_blackman_top.sv
// an accepted sample updates the cell sums, then the output stage registers its result
// one sample per cycle unless out_flt stalls; the chain advances per input transaction
// each cell adds its coefficient times the sample to its neighbor's partial sum
// reset (rst_n, synchronous, active low) clears all partial sums and the result channel
// depends on flb_pkg, flb_sample_if, flb_filtered_if, flb_cell, flb_out_stage
`default_nettype none

module fir_lowpass_blackman_top #(
  parameter int TAPS           = flb_pkg::TapsDef,
  parameter int SAMPLE_BITS    = flb_pkg::SampleBitsDef,
  parameter int COEF_FRAC_BITS = flb_pkg::CoefFracDef
) (
  input wire logic       clk,
  input wire logic       rst_n,
  flb_sample_if.sink     in_smp,
  flb_filtered_if.source out_flt
);
  import flb_pkg::*;

  localparam int AccW = SAMPLE_BITS + CoefW + $clog2(TAPS);

  logic [AccW-1:0] acc [TAPS+1];
  flb_flow_t       flow;

  assign acc[TAPS]    = '0;
  assign in_smp.ready = flow.ready;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    flb_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_W       (AccW),
      .COEF        (flb_coef(k))
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (flow.take),
      .x      (in_smp.sample),
      .acc_in (acc[k+1]),
      .acc_r  (acc[k])
    );
  end

  flb_out_stage #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .ACC_W          (AccW)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_smp.valid),
    .acc0     (acc[0]),
    .flow     (flow),
    .out_flt  (out_flt)
  );

endmodule

`default_nettype wire
